FILE: hw/rtl/pve_pkg.sv
// -----------------------------------------------------------------------------
// pve_pkg
// Opcodes, byte-format codes and shared types for the prefix varint encoder.
// -----------------------------------------------------------------------------
package pve_pkg;

   localparam logic [2:0] OP_SHORT  = 3'd0;
   localparam logic [2:0] OP_INT    = 3'd1;
   localparam logic [2:0] OP_LONG   = 3'd2;
   localparam logic [2:0] OP_LENGTH = 3'd3;
   localparam logic [2:0] OP_USHORT = 3'd4;

   // output layouts picked by the classify stage
   localparam logic [3:0] FMT_S1  = 4'd0;   // signed, 1 byte
   localparam logic [3:0] FMT_S2  = 4'd1;   // signed, 2 bytes
   localparam logic [3:0] FMT_S3  = 4'd2;   // signed short, tag + 16 bits
   localparam logic [3:0] FMT_S4  = 4'd3;   // signed, 4 bytes
   localparam logic [3:0] FMT_S5  = 4'd4;   // signed, tag + 32 bits
   localparam logic [3:0] FMT_S9  = 4'd5;   // signed long, tag + 64 bits
   localparam logic [3:0] FMT_L0  = 4'd6;   // negative length, zero byte
   localparam logic [3:0] FMT_U1  = 4'd7;   // unsigned, 1 byte
   localparam logic [3:0] FMT_U2  = 4'd8;   // unsigned, 2 bytes
   localparam logic [3:0] FMT_L4  = 4'd9;   // length, 4 bytes
   localparam logic [3:0] FMT_L5  = 4'd10;  // length, tag + 32 bits
   localparam logic [3:0] FMT_U3  = 4'd11;  // unsigned short, tag + 16 bits

   localparam int unsigned BUF_BYTES = 9;
   localparam int unsigned BUF_W     = 8 * BUF_BYTES;

   // one encoded item, bytes left aligned, most significant first
   typedef struct packed {
      logic [BUF_W-1:0] bytes;
      logic [3:0]       count;
      logic             over;
   } word_type;

endpackage

FILE: hw/rtl/pve_ser.sv
// -----------------------------------------------------------------------------
// pve_ser
// Byte serializer: loads one encoded item and shifts it out one byte a cycle while rsp_ready is high.
// -----------------------------------------------------------------------------
module pve_ser import pve_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       ld_valid,
   output logic       ld_ready,
   input  word_type   ld_word,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   output logic       rsp_len_over_limit
);

   logic [BUF_W-1:0] buf_ff, buf_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic             over_ff, over_in;
   logic             take;

   assign take     = (cnt_ff != 4'd0) && rsp_ready;
   // refill while the last byte of the current word leaves
   assign ld_ready = (cnt_ff == 4'd0) || ((cnt_ff == 4'd1) && rsp_ready);

   always_comb begin
      buf_in  = buf_ff;
      cnt_in  = cnt_ff;
      over_in = over_ff;
      if (ld_valid && ld_ready) begin
         buf_in  = ld_word.bytes;
         cnt_in  = ld_word.count;
         over_in = ld_word.over;
      end else if (take) begin
         buf_in = {buf_ff[BUF_W-9:0], 8'h00};
         cnt_in = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 4'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      buf_ff  <= buf_in;
      over_ff <= over_in;
   end

   assign rsp_valid          = (cnt_ff != 4'd0);
   assign rsp_out_byte       = buf_ff[BUF_W-1 -: 8];
   assign rsp_last           = (cnt_ff == 4'd1);
   assign rsp_len_over_limit = over_ff;

endmodule

FILE: hw/rtl/prefix_varint_encoder.sv
// -----------------------------------------------------------------------------
// prefix_varint_encoder
// Encodes an opcode and a value into a prefix-tagged big-endian byte string.
// -----------------------------------------------------------------------------
// An item passes three register stages (magnitude, classify, byte build) and
// then a serializer that sends one byte per cycle on the rsp channel while
// rsp_ready is high. An item that encodes to n bytes (1 to 9) holds the
// serializer until its last byte leaves, so the serializer's byte port limits
// throughput: one-byte encodings sustain one item per cycle while rsp_ready
// stays high. Items with an unknown opcode are accepted and dropped without a
// result. len_limit is written through csr_.
module prefix_varint_encoder import pve_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [30:0] csr_len_limit,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic signed [63:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last,
   output logic        rsp_len_over_limit
);

   logic [30:0] limit_ff;

   // stage A: sign and magnitude
   logic        a_valid_ff;
   logic [2:0]  a_op_ff;
   logic        a_neg_ff;
   logic [63:0] a_mag_ff;
   logic [31:0] a_w_ff;
   logic        a_ready;

   // stage B: layout choice
   logic        b_valid_ff;
   logic [3:0]  b_fmt_ff, b_fmt_in;
   logic        b_neg_ff;
   logic [63:0] b_mag_ff;
   logic [31:0] b_w_ff;
   logic        b_over_ff, b_over_in;
   logic        b_ready;

   // stage C: byte image
   logic        c_valid_ff;
   word_type    c_word_ff, c_word_in;
   logic        c_ready;

   logic        ser_ready;

   logic        op_ok;
   logic [31:0] in_w;
   logic        in_neg;
   logic [63:0] in_mag;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_valid) begin
         limit_ff <= csr_len_limit;
      end
   end

   // advance each stage when it is empty or the next one takes its word
   assign c_ready   = !c_valid_ff || ser_ready;
   assign b_ready   = !b_valid_ff || c_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign req_ready = a_ready;

   assign op_ok  = (req_opcode <= OP_USHORT);
   assign in_w   = req_value[31:0];
   assign in_neg = (req_opcode == OP_LONG) ? req_value[63] : in_w[31];

   always_comb begin
      if (req_opcode == OP_LONG) begin
         in_mag = req_value[63] ? (64'd0 - req_value) : req_value;
      end else begin
         in_mag = {32'd0, (in_w[31] ? (32'd0 - in_w) : in_w)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_valid && op_ok;
      end
      if (a_ready) begin
         a_op_ff  <= req_opcode;
         a_neg_ff <= in_neg;
         a_mag_ff <= in_mag;
         a_w_ff   <= in_w;
      end
   end

   always_comb begin
      b_over_in = 1'b0;
      case (a_op_ff)
         OP_SHORT, OP_INT: begin
            if (a_mag_ff < 64'h40) begin
               b_fmt_in = FMT_S1;
            end else if (a_mag_ff < 64'h2000) begin
               b_fmt_in = FMT_S2;
            end else if (a_op_ff == OP_SHORT) begin
               b_fmt_in = FMT_S3;
            end else if (a_mag_ff < 64'h1000_0000) begin
               b_fmt_in = FMT_S4;
            end else begin
               b_fmt_in = FMT_S5;
            end
         end
         OP_LONG: begin
            if (a_mag_ff < 64'h40) begin
               b_fmt_in = FMT_S1;
            end else if (a_mag_ff < 64'h2000) begin
               b_fmt_in = FMT_S2;
            end else if (a_mag_ff < 64'h1000_0000) begin
               b_fmt_in = FMT_S4;
            end else if (a_mag_ff < 64'h7FFF_FFFF) begin
               b_fmt_in = FMT_S5;
            end else begin
               b_fmt_in = FMT_S9;
            end
         end
         OP_LENGTH: begin
            b_over_in = (limit_ff != 31'd0) && !a_neg_ff
                        && (a_w_ff >= {1'b0, limit_ff});
            if (a_neg_ff) begin
               b_fmt_in = FMT_L0;
            end else if (a_w_ff < 32'h80) begin
               b_fmt_in = FMT_U1;
            end else if (a_w_ff < 32'h4000) begin
               b_fmt_in = FMT_U2;
            end else if (a_w_ff < 32'h2000_0000) begin
               b_fmt_in = FMT_L4;
            end else begin
               b_fmt_in = FMT_L5;
            end
         end
         default: begin
            // unsigned short; a negative value keeps only its low seven bits
            if (a_neg_ff || (a_w_ff < 32'h80)) begin
               b_fmt_in = FMT_U1;
            end else if (a_w_ff < 32'h4000) begin
               b_fmt_in = FMT_U2;
            end else begin
               b_fmt_in = FMT_U3;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_ready) begin
         b_fmt_ff  <= b_fmt_in;
         b_over_ff <= b_over_in;
         b_neg_ff  <= a_neg_ff;
         b_mag_ff  <= a_mag_ff;
         b_w_ff    <= a_w_ff;
      end
   end

   always_comb begin
      c_word_in.over  = b_over_ff;
      c_word_in.bytes = '0;
      c_word_in.count = 4'd1;
      case (b_fmt_ff)
         FMT_S1: begin
            c_word_in.bytes[BUF_W-1 -: 8] = {b_neg_ff, 1'b1, b_mag_ff[5:0]};
         end
         FMT_S2: begin
            c_word_in.bytes[BUF_W-1 -: 16] = {b_neg_ff, 2'b01, b_mag_ff[12:0]};
            c_word_in.count = 4'd2;
         end
         FMT_S3: begin
            c_word_in.bytes[BUF_W-1 -: 24] = {b_neg_ff, 7'h10, b_mag_ff[15:0]};
            c_word_in.count = 4'd3;
         end
         FMT_S4: begin
            c_word_in.bytes[BUF_W-1 -: 32] = {b_neg_ff, 3'b001, b_mag_ff[27:0]};
            c_word_in.count = 4'd4;
         end
         FMT_S5: begin
            c_word_in.bytes[BUF_W-1 -: 40] = {b_neg_ff, 7'h08, b_mag_ff[31:0]};
            c_word_in.count = 4'd5;
         end
         FMT_S9: begin
            c_word_in.bytes = {b_neg_ff, 7'h04, b_mag_ff};
            c_word_in.count = 4'd9;
         end
         FMT_L0: begin
            c_word_in.bytes[BUF_W-1 -: 8] = 8'h00;
         end
         FMT_U1: begin
            c_word_in.bytes[BUF_W-1 -: 8] = {1'b1, b_w_ff[6:0]};
         end
         FMT_U2: begin
            c_word_in.bytes[BUF_W-1 -: 16] = {2'b01, b_w_ff[13:0]};
            c_word_in.count = 4'd2;
         end
         FMT_L4: begin
            c_word_in.bytes[BUF_W-1 -: 32] = {3'b001, b_w_ff[28:0]};
            c_word_in.count = 4'd4;
         end
         FMT_L5: begin
            c_word_in.bytes[BUF_W-1 -: 40] = {8'h10, b_w_ff};
            c_word_in.count = 4'd5;
         end
         FMT_U3: begin
            c_word_in.bytes[BUF_W-1 -: 24] = {8'h20, b_w_ff[15:0]};
            c_word_in.count = 4'd3;
         end
         default: begin
            c_word_in.count = 4'd1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_ready) begin
         c_valid_ff <= b_valid_ff;
      end
      if (c_ready) begin
         c_word_ff <= c_word_in;
      end
   end

   pve_ser u_ser (
      .clock              (clock),
      .reset              (reset),
      .ld_valid           (c_valid_ff),
      .ld_ready           (ser_ready),
      .ld_word            (c_word_ff),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last           (rsp_last),
      .rsp_len_over_limit (rsp_len_over_limit)
   );

endmodule

FILE: verif/prefix_varint_encoder_test.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// prefix_varint_encoder_test
// Self-checking bench for the prefix varint encoder. Items go in on req_,
// each is encoded by a local predictor into its expected bytes, and every word
// on rsp_ is compared in order. Runs directed corners, limit-register sweeps,
// random mixes under sender and receiver idling, and a long output stall.
// -----------------------------------------------------------------------------
module prefix_varint_encoder_test;
   import pve_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_CYCLES  = 300;
   localparam logic [2:0] OP_RESERVED_LO = 3'd5;
   localparam logic [2:0] OP_RESERVED_HI = 3'd7;
   localparam logic [30:0] LIMIT_OFF = 31'd0;
   localparam logic [30:0] LIMIT_MAX = 31'h7FFF_FFFF;
   localparam logic [63:0] VALUE_BOUNDS [9] = '{
      64'h40, 64'h80, 64'h2000, 64'h4000, 64'h1000_0000, 64'h2000_0000,
      64'h7FFF_FFFF, 64'h8000_0000, 64'h8000_0000_0000_0000};

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic       over;
   } encoded_byte_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [30:0] csr_len_limit = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_opcode = OP_SHORT;
   logic signed [63:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;
   logic        rsp_len_over_limit;

   encoded_byte_type expected_bytes[$];
   logic [30:0] len_limit_model = '0;
   int error_count   = 0;
   int bytes_checked = 0;
   int items_sent    = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_len      = 0;
   int hold_seq      = 0;
   int hold_seen     = 0;
   int hold_left     = 0;

   prefix_varint_encoder uut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_len_limit      (csr_len_limit),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last           (rsp_last),
      .rsp_len_over_limit (rsp_len_over_limit)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Work out the byte string for one item: an optional tag byte, then a body
   // of body_len bytes sent most significant first.
   function automatic void predict_encoding(input logic [2:0] op, input logic [63:0] val);
      logic [31:0] w;
      logic [31:0] mag32;
      logic [63:0] mag64;
      logic [7:0]  sgn;
      logic        has_tag;
      logic [7:0]  tag;
      logic [63:0] body;
      int          body_len;
      int          total;
      int          idx;
      logic        over;
      encoded_byte_type eb;
      w        = val[31:0];
      mag32    = w[31] ? 32'd0 - w : w;
      sgn      = w[31] ? 8'h80 : 8'h00;
      has_tag  = 1'b0;
      tag      = 8'h00;
      body     = '0;
      body_len = 0;
      over     = 1'b0;
      case (op)
         OP_SHORT, OP_INT: begin
            if (mag32 < 32'h40) begin
               body = {56'd0, sgn | 8'h40 | mag32[7:0]};
               body_len = 1;
            end else if (mag32 < 32'h2000) begin
               body = {48'd0, {sgn, 8'h00} | 16'h2000 | mag32[15:0]};
               body_len = 2;
            end else if (op == OP_SHORT) begin
               // too-large magnitudes keep only their low 16 bits
               has_tag = 1'b1;
               tag = sgn | 8'h10;
               body = {48'd0, mag32[15:0]};
               body_len = 2;
            end else if (mag32 < 32'h1000_0000) begin
               body = {32'd0, {sgn, 24'd0} | 32'h1000_0000 | mag32};
               body_len = 4;
            end else begin
               has_tag = 1'b1;
               tag = sgn | 8'h08;
               body = {32'd0, mag32};
               body_len = 4;
            end
         end
         OP_LONG: begin
            mag64 = val[63] ? 64'd0 - val : val;
            sgn   = val[63] ? 8'h80 : 8'h00;
            if (mag64 < 64'h40) begin
               body = {56'd0, sgn | 8'h40 | mag64[7:0]};
               body_len = 1;
            end else if (mag64 < 64'h2000) begin
               body = {48'd0, {sgn, 8'h00} | 16'h2000 | mag64[15:0]};
               body_len = 2;
            end else if (mag64 < 64'h1000_0000) begin
               body = {32'd0, {sgn, 24'd0} | 32'h1000_0000 | mag64[31:0]};
               body_len = 4;
            end else if (mag64 < 64'h7FFF_FFFF) begin
               has_tag = 1'b1;
               tag = sgn | 8'h08;
               body = {32'd0, mag64[31:0]};
               body_len = 4;
            end else begin
               has_tag = 1'b1;
               tag = sgn | 8'h04;
               body = mag64;
               body_len = 8;
            end
         end
         OP_LENGTH: begin
            over = (len_limit_model != 31'd0) && !w[31] && (w >= {1'b0, len_limit_model});
            if (w[31]) begin
               body_len = 1;
            end else if (w < 32'h80) begin
               body = {56'd0, w[7:0] | 8'h80};
               body_len = 1;
            end else if (w < 32'h4000) begin
               body = {48'd0, w[15:0] | 16'h4000};
               body_len = 2;
            end else if (w < 32'h2000_0000) begin
               body = {32'd0, w | 32'h2000_0000};
               body_len = 4;
            end else begin
               has_tag = 1'b1;
               tag = 8'h10;
               body = {32'd0, w};
               body_len = 4;
            end
         end
         OP_USHORT: begin
            // negative values fall into the one-byte form
            if (w[31] || w < 32'h80) begin
               body = {56'd0, w[7:0] | 8'h80};
               body_len = 1;
            end else if (w < 32'h4000) begin
               body = {48'd0, w[15:0] | 16'h4000};
               body_len = 2;
            end else begin
               has_tag = 1'b1;
               tag = 8'h20;
               body = {48'd0, w[15:0]};
               body_len = 2;
            end
         end
         default: ;  // reserved opcodes are dropped
      endcase
      total = body_len + (has_tag ? 1 : 0);
      for (int k = 0; k < total; k++) begin
         idx = has_tag ? k - 1 : k;
         eb.data = (has_tag && k == 0) ? tag : body[8*(body_len-1-idx) +: 8];
         eb.last = (k == total - 1);
         eb.over = over;
         expected_bytes.push_back(eb);
      end
   endfunction

   // Predict on each accepted item, track the limit register, check each word.
   always @(posedge clock) begin : scoreboard
      encoded_byte_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_encoding(req_opcode, req_value);
         end
         if (csr_valid && csr_ready) begin
            len_limit_model = csr_len_limit;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               $error("out_byte: expected no word, got %02h", rsp_out_byte);
               error_count++;
            end else begin
               want = expected_bytes.pop_front();
               bytes_checked++;
               if (rsp_out_byte !== want.data) begin
                  $error("out_byte: expected %02h, got %02h", want.data, rsp_out_byte);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_last);
                  error_count++;
               end
               if (rsp_len_over_limit !== want.over) begin
                  $error("len_over_limit: expected %0b, got %0b", want.over,
                         rsp_len_over_limit);
                  error_count++;
               end
            end
         end
      end
   end

   // Receiver: random stalls, or a long hold-off when the test asks for one.
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= hold_len;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Offer one item and hold it until accepted; valid stays up if no gap follows.
   task automatic send_word(input logic [2:0] op, input logic [63:0] val);
      int gap;
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_value  <= val;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 24) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid, let every expected word arrive, then let dropped items flush.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [30:0] lim);
      wait_drained();
      csr_valid     <= 1'b1;
      csr_len_limit <= lim;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [2:0] pick_opcode();
      if ($urandom_range(15) == 0) begin
         return 3'($urandom_range(OP_RESERVED_HI, OP_RESERVED_LO));
      end
      return 3'($urandom_range(OP_USHORT, OP_SHORT));
   endfunction

   // Mostly small magnitudes and values near the format boundaries, some raw.
   function automatic logic [63:0] pick_value(input logic [2:0] op);
      logic [63:0] raw;
      logic [63:0] mag;
      int          sel;
      raw = {$urandom, $urandom};
      sel = $urandom_range(5);
      if (sel >= 4) begin
         return raw;
      end
      case (sel)
         0:       mag = 64'($urandom_range(32'hFF));
         1:       mag = 64'($urandom_range(32'h7FFF));
         2:       mag = 64'($urandom_range(32'h3FFF_FFFF));
         default: mag = VALUE_BOUNDS[$urandom_range(8)] + 64'($urandom_range(2)) - 64'd1;
      endcase
      if ($urandom_range(1) == 1) begin
         mag = 64'd0 - mag;
      end
      if (op == OP_LONG) begin
         return mag;
      end
      return {raw[63:32], mag[31:0]};
   endfunction

   task automatic test_directed();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_word(OP_SHORT,  64'hDEAD_BEEF_0000_003F);
      send_word(OP_SHORT,  64'h0000_0000_FFFF_FFC0);
      send_word(OP_SHORT,  64'h1234_5678_0000_1FFF);
      send_word(OP_SHORT,  64'h0000_0000_7FFF_FFFF);
      send_word(OP_SHORT,  64'hFFFF_FFFF_8000_0000);
      send_word(OP_INT,    64'h0000_0000_0FFF_FFFF);
      send_word(OP_INT,    64'h0000_0000_F000_0000);
      send_word(OP_INT,    64'h5555_AAAA_8000_0000);
      send_word(OP_LONG,   64'h0);
      send_word(OP_LONG,   64'h0000_0000_7FFF_FFFE);
      send_word(OP_LONG,   64'h0000_0000_7FFF_FFFF);
      send_word(OP_LONG,   64'h8000_0000_0000_0000);
      send_word(OP_LONG,   64'h7FFF_FFFF_FFFF_FFFF);
      send_word(OP_LONG,   64'hFFFF_FFFF_FFFF_FFFF);
      send_word(OP_LENGTH, 64'h0000_0000_FFFF_FFFF);
      send_word(OP_LENGTH, 64'h0000_0000_0000_007F);
      send_word(OP_LENGTH, 64'hA5A5_0000_0000_3FFF);
      send_word(OP_LENGTH, 64'h0000_0000_1FFF_FFFF);
      send_word(OP_LENGTH, 64'h0000_0000_7FFF_FFFF);
      send_word(OP_USHORT, 64'h0000_0000_0000_007F);
      send_word(OP_USHORT, 64'hFFFF_FFFF_FFFF_FFF6);
      send_word(OP_USHORT, 64'h0000_0000_0000_3FFF);
      send_word(OP_USHORT, 64'h0000_0000_7FFF_1234);
      send_word(OP_RESERVED_LO, 64'h0000_0000_0000_0001);
      send_word(OP_RESERVED_HI, 64'hFFFF_FFFF_FFFF_FFFF);
      wait_drained();
   endtask

   // Length items just below, at and above each limit setting.
   task automatic test_len_limit();
      logic [30:0] limits[4];
      logic [31:0] probe;
      limits = '{31'd1, LIMIT_MAX, 31'($urandom_range(32'h3FFF_FFFF, 32'h80)), LIMIT_OFF};
      foreach (limits[i]) begin
         write_limit(limits[i]);
         for (int k = 0; k < 3; k++) begin
            probe = {1'b0, limits[i]} + 32'(k) - 32'd1;
            send_word(OP_LENGTH, {$urandom, probe});
         end
         send_word(OP_LENGTH, {$urandom, 32'd0 - 32'($urandom_range(1000, 1))});
         send_word(OP_LENGTH, pick_value(OP_LENGTH));
      end
      wait_drained();
   endtask

   task automatic test_random_mix(input int count, input int idle_pct, input int stall_pct);
      logic [2:0] op;
      int         known;
      write_limit(31'($urandom_range(32'hFFFF, 1)));
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      known = 0;
      while (known < count) begin
         op = pick_opcode();
         send_word(op, pick_value(op));
         if (op <= OP_USHORT) known++;
      end
      wait_drained();
   endtask

   // Hold the output off while items keep coming, so the input backs up.
   task automatic test_output_stall();
      logic [2:0] op;
      write_limit(LIMIT_MAX);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_len = HOLD_CYCLES;
      hold_seq++;
      for (int i = 0; i < 30; i++) begin
         op = 3'($urandom_range(OP_USHORT, OP_SHORT));
         send_word(op, pick_value(op));
      end
      wait_drained();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_len_limit();
      test_random_mix(60, 0, 0);
      test_random_mix(60, 54, 0);
      test_random_mix(60, 0, 54);
      test_random_mix(60, 28, 28);
      test_output_stall();
      wait_drained();
      $display("Sent %0d items over all five formats and reserved opcodes, checked %0d bytes,",
               items_sent, bytes_checked);
      $display("with len_limit at 0, 1, max and random, under idling and a long output stall.");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
